// ----- design/cfa_pkg.sv -----
// Package for the contiguous-fit allocator: status, request codes, policy codes.
// No dependencies.
package cfa_pkg;
  localparam int MEM_UNITS_DEF = 256;
  localparam int OWNER_W = 16;
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE = 2'd1;
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT = 2'd1;
  localparam logic [1:0] POL_BEST = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OK_COMPACT = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE = 3'd3;
  localparam logic [2:0] ST_IDS_OUT = 3'd4;
  localparam logic [15:0] ID_LAST = 16'hFFFF;
endpackage

// ----- design/contiguous_fit_allocator.sv -----
// Top level of the contiguous-fit allocator: owner memory, scan sequencer.
// Depends on cfa_pkg.
//
//  channel | ports                                   | handshake
//  in      | in_req_type, in_alloc_size, in_free_id  | start & !busy
//  out     | out_status .. out_largest_free_run      | out_valid, one cycle, no stall
//  cfg     | cfg_fit_policy                          | cfg_valid & cfg_ready
//
// One word per request; each request runs as passes over the
// single-port owner memory (one read or one write per unit per cycle):
//   clear pass after reset, start not taken meanwhile.
//   query: measure pass; free: free pass, then measure; allocate with
//   compaction: scan, next-fit rescan, compact, two rescans, write run,
//   measure.
// The result strobe lasts one cycle; the receiver cannot stall the block.
module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS = MEM_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [8:0]  in_alloc_size,
  input  logic [15:0] in_free_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_assigned_id,
  output logic [7:0]  out_start_unit,
  output logic [8:0]  out_free_units,
  output logic [8:0]  out_largest_free_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_fit_policy
);
  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] NU = CW'(MEM_UNITS);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_FREE  = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_CFILL = 10'b0000100000,
    S_WRUN  = 10'b0001000000,
    S_MEAS  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_DEC   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [OWNER_W-1:0] mem [MEM_UNITS];
  logic [OWNER_W-1:0] rd_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr;
  logic [OWNER_W-1:0] wdata;

  logic [1:0]  pol_r;
  logic [1:0]  req_r;
  logic [CW-1:0] size_r;
  logic [15:0] fid_r, idc_r, idc_nxt;
  logic [CW-1:0] nxs_r, nxs_nxt;
  // scan control: read index (issue), data index (the unit rd_q belongs to)
  logic [CW-1:0] ri_r, ri_nxt, di_r, di_nxt;
  logic          dv_r, dv_nxt;
  logic [CW-1:0] from_r, from_nxt;
  logic [CW-1:0] rs_r, rs_nxt, rl_r, rl_nxt;
  logic [CW-1:0] pk_r, pk_nxt, pl_r, pl_nxt;
  logic          hit_r, hit_nxt;
  logic          phase2_r, phase2_nxt, cmpd_r, cmpd_nxt;
  logic [CW-1:0] wp_r, wp_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [15:0] aid_r, aid_nxt;
  logic [7:0]  su_r, su_nxt;
  logic [CW-1:0] fc_r, fc_nxt, big_r, big_nxt;
  logic        ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rd_q <= mem[raddr];
  end

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLR);

  function automatic logic [CW-1:0] rl_cur_len(input logic [CW-1:0] rl, input logic f);
    rl_cur_len = f ? rl + 1'b1 : rl;
  endfunction

  // flags of the word now in rd_q: free (at or past from_r), last unit
  logic dfree, dend, run_done;
  logic [CW-1:0] rl_cur;
  always_comb begin
    dfree = dv_r && (di_r >= from_r) && (rd_q == '0);
    dend  = dv_r && (di_r == NU - 1'b1);
    rl_cur = dfree ? rl_r + 1'b1 : '0;
  end

  always_comb begin
    state_nxt = state_r;
    idc_nxt = idc_r; nxs_nxt = nxs_r;
    ri_nxt = ri_r; di_nxt = di_r; dv_nxt = 1'b0;
    from_nxt = from_r; rs_nxt = rs_r; rl_nxt = rl_r;
    pk_nxt = pk_r; pl_nxt = pl_r; hit_nxt = hit_r;
    phase2_nxt = phase2_r; cmpd_nxt = cmpd_r; wp_nxt = wp_r;
    st_nxt = st_r; aid_nxt = aid_r; su_nxt = su_r;
    fc_nxt = fc_r; big_nxt = big_r; ov_nxt = 1'b0;
    mem_we = 1'b0; mem_re = 1'b0;
    waddr = ri_r[AW-1:0]; raddr = ri_r[AW-1:0]; wdata = '0;
    run_done = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        ri_nxt = ri_r + 1'b1;
        if (ri_r == NU - 1'b1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          st_nxt = ST_OK; aid_nxt = '0; su_nxt = '0;
          ri_nxt = '0; rl_nxt = '0; hit_nxt = 1'b0; from_nxt = '0;
          phase2_nxt = 1'b0; cmpd_nxt = 1'b0; fc_nxt = '0; big_nxt = '0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (req_r == REQ_ALLOC) begin
          if (size_r == '0 || size_r > NU) begin
            st_nxt = ST_BAD_SIZE; state_nxt = S_MEAS;
          end else if (idc_r == ID_LAST) begin
            st_nxt = ST_IDS_OUT; state_nxt = S_MEAS;
          end else begin
            if (pol_r == POL_NEXT) begin
              from_nxt = nxs_r;
            end
            state_nxt = S_SCAN;
          end
        end else if (req_r == REQ_FREE) begin
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_MEAS;
        end
      end
      S_SCAN: begin
        // stream reads; rd_q is valid in the next cycle
        if (ri_r < NU) begin
          mem_re = 1'b1; ri_nxt = ri_r + 1'b1;
          di_nxt = ri_r; dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if (dfree && rl_r == '0) rs_nxt = di_r;
          rl_nxt = rl_cur;
          // a run closes at a used unit or at the end
          if ((!dfree || dend) && rl_r + (dfree ? 1'b1 : 1'b0) >= size_r
              && rl_r + (dfree ? 1'b1 : 1'b0) != '0) begin
            if (!hit_r || (pol_r == POL_BEST && rl_cur_len(rl_r, dfree) < pl_r)
                || (pol_r == POL_WORST && rl_cur_len(rl_r, dfree) > pl_r)) begin
              pk_nxt = (dfree && rl_r == '0) ? di_r : rs_r;
              pl_nxt = rl_cur_len(rl_r, dfree);
              hit_nxt = 1'b1;
            end
          end
          if (dend) run_done = 1'b1;
        end
        if (run_done) begin
          if (hit_nxt) begin
            state_nxt = S_WRUN;
            wp_nxt = pk_nxt;
            idc_nxt = idc_r + 1'b1;
            aid_nxt = idc_r + 1'b1;
            su_nxt = 8'(pk_nxt);
            st_nxt = cmpd_r ? ST_OK_COMPACT : ST_OK;
            if (pol_r == POL_NEXT) nxs_nxt = CW'((pk_nxt + size_r) & 9'h1FF);
          end else if (pol_r == POL_NEXT && !phase2_r && from_r != '0) begin
            phase2_nxt = 1'b1; from_nxt = '0; ri_nxt = '0; rl_nxt = '0;
          end else if (!cmpd_r) begin
            state_nxt = S_CMP; ri_nxt = '0; wp_nxt = '0;
          end else begin
            st_nxt = ST_NO_SPACE; state_nxt = S_MEAS; ri_nxt = '0; rl_nxt = '0;
          end
        end
      end
      S_CMP: begin
        // read unit ri; when data arrives write owned ones at wp
        if (ri_r < NU && !(dv_r && rd_q != '0)) begin
          mem_re = 1'b1; ri_nxt = ri_r + 1'b1; di_nxt = ri_r; dv_nxt = 1'b1;
        end
        if (dv_r && rd_q != '0) begin
          mem_we = 1'b1; waddr = wp_r[AW-1:0]; wdata = rd_q;
          wp_nxt = wp_r + 1'b1;
        end
        if (dend || (ri_r == NU && !dv_r)) begin
          state_nxt = S_CFILL;
        end
        if (dv_r && rd_q != '0 && dend) wp_nxt = wp_r + 1'b1;
      end
      S_CFILL: begin
        if (wp_r == NU) begin
          cmpd_nxt = 1'b1; phase2_nxt = 1'b0; hit_nxt = 1'b0;
          ri_nxt = '0; rl_nxt = '0;
          from_nxt = (pol_r == POL_NEXT) ? nxs_r : '0;
          state_nxt = S_SCAN;
        end else begin
          mem_we = 1'b1; waddr = wp_r[AW-1:0]; wdata = '0;
          wp_nxt = wp_r + 1'b1;
        end
      end
      S_WRUN: begin
        if (wp_r == NU || wp_r == pk_r + size_r) begin
          state_nxt = S_MEAS; ri_nxt = '0; rl_nxt = '0; from_nxt = '0;
        end else begin
          mem_we = 1'b1; waddr = wp_r[AW-1:0]; wdata = idc_r;
          wp_nxt = wp_r + 1'b1;
        end
      end
      S_FREE: begin
        // read-modify-write; reads pause on a write cycle (single port)
        if (ri_r < NU && !(dv_r && rd_q == fid_r)) begin
          mem_re = 1'b1; ri_nxt = ri_r + 1'b1; di_nxt = ri_r; dv_nxt = 1'b1;
        end
        if (dv_r && rd_q == fid_r) begin
          mem_we = 1'b1; waddr = di_r[AW-1:0]; wdata = '0;
        end
        if (dend || (ri_r == NU && !dv_r)) begin
          state_nxt = S_MEAS; ri_nxt = '0; rl_nxt = '0; from_nxt = '0;
        end
      end
      S_MEAS: begin
        if (ri_r < NU) begin
          mem_re = 1'b1; ri_nxt = ri_r + 1'b1; di_nxt = ri_r; dv_nxt = 1'b1;
        end
        if (dv_r) begin
          rl_nxt = rl_cur;
          if (dfree) fc_nxt = fc_r + 1'b1;
          if (rl_cur > big_r) big_nxt = rl_cur;
          if (dend) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; ri_r <= '0; dv_r <= 1'b0; ov_r <= 1'b0;
      idc_r <= '0; nxs_r <= '0; pol_r <= POL_FIRST;
    end else begin
      state_r <= state_nxt; ri_r <= ri_nxt; dv_r <= dv_nxt; ov_r <= ov_nxt;
      idc_r <= idc_nxt; nxs_r <= nxs_nxt;
      if (cfg_valid && cfg_ready) pol_r <= cfg_fit_policy;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_req_type; fid_r <= in_free_id;
      size_r <= (int'(in_alloc_size) > MEM_UNITS) ? NU + 1'b1 : CW'(in_alloc_size);
    end
    di_r <= di_nxt; from_r <= from_nxt; rs_r <= rs_nxt; rl_r <= rl_nxt;
    pk_r <= pk_nxt; pl_r <= pl_nxt; hit_r <= hit_nxt; phase2_r <= phase2_nxt;
    cmpd_r <= cmpd_nxt; wp_r <= wp_nxt; st_r <= st_nxt; aid_r <= aid_nxt;
    su_r <= su_nxt; fc_r <= fc_nxt; big_r <= big_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_assigned_id = aid_r;
  assign out_start_unit = su_r;
  assign out_free_units = 9'(fc_r);
  assign out_largest_free_run = 9'(big_r);

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !$past(out_valid))
    else $error("double strobe");
  a_big: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> big_r <= fc_r)
    else $error("largest run above free count");
  a_rw: assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
    else $error("port conflict");
endmodule
